// File: rtl/lbps_pkg.sv
// lbps_pkg: shared types and constants of the led and buzzer pattern sequencer
// pattern codes, pattern periods and the sequencer state record
// no dependencies
`default_nettype none

package lbps_pkg;

    localparam int PatW   = 4;
    localparam int PhaseW = 12;
    localparam int LedW   = 3;

    localparam logic [PatW-1:0] PAT_OFF        = 4'd0;
    localparam logic [PatW-1:0] PAT_IDLE       = 4'd1;
    localparam logic [PatW-1:0] PAT_OFFLINE    = 4'd2;
    localparam logic [PatW-1:0] PAT_WAITING    = 4'd3;
    localparam logic [PatW-1:0] PAT_APPROACHED = 4'd4;
    localparam logic [PatW-1:0] PAT_DISPENSING = 4'd5;
    localparam logic [PatW-1:0] PAT_PICKUP     = 4'd6;
    localparam logic [PatW-1:0] PAT_MISSED     = 4'd7;
    localparam logic [PatW-1:0] PAT_ERROR      = 4'd8;
    localparam logic [PatW-1:0] PAT_CONFIG     = 4'd9;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SELECT = 1'b1;

    localparam logic [PhaseW-1:0] PICKUP_END = 12'd1200;

    typedef struct packed {
        logic [PatW-1:0]   pattern;
        logic [PhaseW-1:0] phase;
        logic [LedW-1:0]   led;
        logic              buzzer_n;
    } t_state;

    function automatic logic [PhaseW-1:0] period_of(input logic [PatW-1:0] p);
        logic [PhaseW-1:0] per;
        case (p)
            PAT_IDLE:       per = 12'd3000;
            PAT_OFFLINE:    per = 12'd1500;
            PAT_WAITING:    per = 12'd1000;
            PAT_APPROACHED: per = 12'd400;
            PAT_MISSED:     per = 12'd2000;
            PAT_ERROR:      per = 12'd900;
            PAT_CONFIG:     per = 12'd1200;
            default:        per = '0;
        endcase
        return per;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lbps_step.sv
// lbps_step: next state of the sequencer for one item
// pure combinational; uses lbps_pkg
`default_nettype none

module lbps_step (
    input  wire logic                            i_op,
    input  wire logic [lbps_pkg::PatW-1:0]       i_pattern,
    input  wire lbps_pkg::t_state                i_cur,
    output lbps_pkg::t_state                     o_next
);

    localparam int G = 0;
    localparam int R = 1;
    localparam int B = 2;

    logic [lbps_pkg::PhaseW-1:0] per;
    logic [lbps_pkg::PhaseW-1:0] ph;
    logic [lbps_pkg::PhaseW-1:0] ph_inc;
    lbps_pkg::t_state            t;

    function automatic logic win(input logic [lbps_pkg::PhaseW-1:0] v,
                                 input logic [lbps_pkg::PhaseW-1:0] a,
                                 input logic [lbps_pkg::PhaseW-1:0] b);
        return (v >= a) && (v < b);
    endfunction

    assign per    = lbps_pkg::period_of(i_cur.pattern);
    assign ph     = i_cur.phase;
    assign ph_inc = ph + 12'd1;

    always_comb begin
        t = i_cur;
        if (i_op == lbps_pkg::OP_SELECT) begin
            if (i_pattern <= lbps_pkg::PAT_CONFIG && i_pattern != i_cur.pattern) begin
                t.pattern  = i_pattern;
                t.phase    = '0;
                t.led      = '0;
                t.buzzer_n = 1'b1;
            end
        end else begin
            case (i_cur.pattern)
                lbps_pkg::PAT_IDLE: begin
                    t.led[G]   = ph < 12'd120;
                    t.led[R]   = 1'b0;
                    t.led[B]   = 1'b0;
                    t.buzzer_n = 1'b1;
                end
                lbps_pkg::PAT_OFFLINE: begin
                    t.led[R]   = ph < 12'd750;
                    t.led[G]   = 1'b0;
                    t.led[B]   = 1'b0;
                    t.buzzer_n = 1'b1;
                end
                lbps_pkg::PAT_WAITING: begin
                    t.led[B]   = ph < 12'd500;
                    t.buzzer_n = !(ph < 12'd180);
                end
                lbps_pkg::PAT_APPROACHED: begin
                    t.led[G]   = ph < 12'd200;
                    t.buzzer_n = !(ph < 12'd100);
                end
                lbps_pkg::PAT_DISPENSING: begin
                    t.led[B]   = 1'b1;
                    t.buzzer_n = 1'b1;
                end
                lbps_pkg::PAT_PICKUP: begin
                    t.buzzer_n = 1'b1;
                    t.led[G]   = (ph < 12'd120) || win(ph, 12'd220, 12'd340);
                end
                lbps_pkg::PAT_MISSED: begin
                    t.led[R]   = ph < 12'd1000;
                    t.buzzer_n = !((ph < 12'd150) || win(ph, 12'd250, 12'd400)
                                   || win(ph, 12'd500, 12'd650));
                end
                lbps_pkg::PAT_ERROR: begin
                    t.led[R]   = ph < 12'd450;
                    t.buzzer_n = !((ph < 12'd100) || win(ph, 12'd150, 12'd250)
                                   || win(ph, 12'd300, 12'd400));
                end
                lbps_pkg::PAT_CONFIG: begin
                    t.led[B]   = ph < 12'd600;
                    t.led[G]   = win(ph, 12'd600, 12'd1200);
                    t.buzzer_n = 1'b0;
                end
                default: begin
                    t.buzzer_n = 1'b1;
                end
            endcase

            if (i_cur.pattern == lbps_pkg::PAT_PICKUP) begin
                if (ph >= lbps_pkg::PICKUP_END) begin
                    t.pattern  = lbps_pkg::PAT_IDLE;
                    t.phase    = '0;
                    t.led      = '0;
                    t.buzzer_n = 1'b1;
                end else begin
                    t.phase = ph_inc;
                end
            end else if (per != '0) begin
                t.phase = (ph_inc >= per) ? '0 : ph_inc;
            end else begin
                t.phase = '0;
            end
        end
    end

    assign o_next = t;

endmodule

`default_nettype wire

// File: rtl/led_buzzer_pattern_sequencer_top.sv
// led_buzzer_pattern_sequencer_top: top level of the led and buzzer sequencer
// input register, state and result register; uses lbps_pkg and lbps_step
//
// usage:
//   input channel: i_valid / o_stall with i_op and i_pattern. i_op low is a
//   one millisecond tick, i_op high selects i_pattern (codes above 9 ignored).
//   output channel: o_valid / i_stall with the three led drives, the active
//   low buzzer drive and the pattern in force after the item.
//   every item gives exactly one result, in order.
//   result: the item waits in the input register; its result is valid once
//   the item moves on from the input register into the result register.
//   throughput: one item per cycle while the output is not stalled; the
//   phase update is a single compare and increment between the input
//   register and the state register.
//   stall: while the result register is full and stalled, the input register
//   still takes one item; only with both full is o_stall raised.
//   reset: synchronous active low on i_rst_n; pattern off, phase zero, leds
//   off, buzzer silent, both registers empty.
`default_nettype none

module led_buzzer_pattern_sequencer_top (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_op,
    input  wire logic [lbps_pkg::PatW-1:0]  i_pattern,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic                            o_led_green,
    output logic                            o_led_red,
    output logic                            o_led_blue,
    output logic                            o_buzzer_n,
    output logic [lbps_pkg::PatW-1:0]       o_active_pattern
);

    logic                        r_in_valid;
    logic                        r_in_op;
    logic [lbps_pkg::PatW-1:0]   r_in_pattern;
    lbps_pkg::t_state            r_state;
    lbps_pkg::t_state            n_state;
    lbps_pkg::t_state            r_out;
    logic                        r_out_valid;
    logic                        advance;
    logic                        in_accept;

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    lbps_step u_step (
        .i_op      (r_in_op),
        .i_pattern (r_in_pattern),
        .i_cur     (r_state),
        .o_next    (n_state)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid       <= 1'b0;
            r_out_valid      <= 1'b0;
            r_state.pattern  <= lbps_pkg::PAT_OFF;
            r_state.phase    <= '0;
            r_state.led      <= '0;
            r_state.buzzer_n <= 1'b1;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_op      <= i_op;
            r_in_pattern <= i_pattern;
        end
        if (advance) begin
            r_out <= n_state;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_led_green      = r_out.led[0];
    assign o_led_red        = r_out.led[1];
    assign o_led_blue       = r_out.led[2];
    assign o_buzzer_n       = r_out.buzzer_n;
    assign o_active_pattern = r_out.pattern;

`ifndef NO_ASSERTIONS
    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pattern == lbps_pkg::PAT_PICKUP) ?
            (r_state.phase <= lbps_pkg::PICKUP_END) :
            (r_state.phase == '0 ||
             r_state.phase < lbps_pkg::period_of(r_state.pattern)))
        else $error("phase beyond pattern period");

    a_pattern_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.pattern <= lbps_pkg::PAT_CONFIG)
        else $error("unknown pattern in force");

    a_static_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.pattern == lbps_pkg::PAT_OFF ||
         r_state.pattern == lbps_pkg::PAT_DISPENSING) |-> r_state.phase == '0)
        else $error("phase moving in a pattern without a cycle");

    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_active_pattern == r_state.pattern)
        else $error("result out of step with state");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled while a register is free");
`endif

endmodule

`default_nettype wire
